### hdl/twdb_pkg.sv
package twdb_pkg;

    localparam int OCC_W   = 7;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;

    localparam logic             REG_MAX_AGE   = 1'b0;
    localparam logic [CFG_W-1:0] MAX_AGE_RESET = 32'd1000000;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_READ,
        S_ITEM,
        S_NOTE
    } state_t;

    typedef struct packed {
        logic accept;
        logic evict_step;
        logic walk_read;
        logic load_item;
        logic walk_advance;
        logic load_note;
    } dp_ctl_t;

    typedef struct packed {
        cmd_t command;
        logic evict_go;
        logic n_zero;
        logic too_old;
        logic walk_last;
        logic out_free;
    } dp_sts_t;

endpackage

### hdl/twdb_if.sv
interface twdb_in_if #(
    parameter int PAYLOAD_BITS = 64,
    parameter int STAMP_BITS   = 48
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [STAMP_BITS-1:0]   stamp;
    logic                    from_newest;
    logic signed [7:0]       count;

    modport source (output valid, command, payload, stamp, from_newest, count, input ready);
    modport sink   (input valid, command, payload, stamp, from_newest, count, output ready);
endinterface

interface twdb_out_if #(
    parameter int PAYLOAD_BITS = 64,
    parameter int STAMP_BITS   = 48
);
    logic                    valid;
    logic                    ready;
    logic                    has_item;
    logic [PAYLOAD_BITS-1:0] item_payload;
    logic [STAMP_BITS-1:0]   item_stamp;
    logic                    last;
    logic [6:0]              occupancy;
    logic [6:0]              dropped;
    logic                    overflow;

    modport source (output valid, has_item, item_payload, item_stamp, last, occupancy,
                    dropped, overflow, input ready);
    modport sink   (input valid, has_item, item_payload, item_stamp, last, occupancy,
                    dropped, overflow, output ready);
endinterface

### hdl/twdb_regs.sv
module twdb_regs
    import twdb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic [CFG_W-1:0]  max_age
);

    logic [CFG_W-1:0] max_age_reg;
    logic             hit_max_age;

    assign hit_max_age = (paddr[ADDR_W-1] == REG_MAX_AGE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= MAX_AGE_RESET;
        end
        else if (psel && penable && pwrite && hit_max_age)
        begin
            max_age_reg <= pwdata;
        end
    end

    assign prdata  = hit_max_age ? max_age_reg : '0;
    assign max_age = max_age_reg;

endmodule

### hdl/twdb_ctrl.sv
module twdb_ctrl
    import twdb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (sts.command)
                        CMD_PUSH:  state_next = sts.evict_go ? S_EVICT : S_NOTE;
                        CMD_CLEAR: state_next = S_NOTE;
                        CMD_PEEK, CMD_POP:
                                   state_next = sts.n_zero ? S_NOTE : S_READ;
                        default:   state_next = S_NOTE;
                    endcase
                end
            end
            S_EVICT:
            begin
                if (!sts.too_old)
                begin
                    state_next = S_NOTE;
                end
            end
            S_READ:
            begin
                state_next = S_ITEM;
            end
            S_ITEM:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.walk_last ? S_IDLE : S_READ;
                end
            end
            S_NOTE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == S_IDLE);
        ctl.accept       = (state_reg == S_IDLE) && in_valid;
        ctl.evict_step   = (state_reg == S_EVICT) && sts.too_old;
        ctl.walk_read    = (state_reg == S_READ);
        ctl.load_item    = (state_reg == S_ITEM) && sts.out_free;
        ctl.walk_advance = (state_reg == S_ITEM) && sts.out_free && !sts.walk_last;
        ctl.load_note    = (state_reg == S_NOTE) && sts.out_free;
    end

endmodule

### hdl/twdb_dp.sv
module twdb_dp
    import twdb_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 64,
    parameter int STAMP_BITS   = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              command,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic [STAMP_BITS-1:0]   stamp,
    input  logic                    from_newest,
    input  logic [COUNT_W-1:0]      count,
    input  logic [CFG_W-1:0]        max_age,
    input  dp_ctl_t                 ctl,
    output dp_sts_t                 sts,
    twdb_out_if.source              rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int MW = PAYLOAD_BITS + STAMP_BITS;
    localparam int CW = (STAMP_BITS > CFG_W) ? STAMP_BITS : CFG_W;

    function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[IW-1:0];
    endfunction

    logic [MW-1:0] mem [DEPTH];

    logic [IW-1:0]           oldest_reg;
    logic [FW-1:0]           fill_reg;
    logic [IW-1:0]           walk_reg;
    logic [FW-1:0]           remain_reg;
    logic [STAMP_BITS-1:0]   stamp_reg;
    logic [FW-1:0]           drp_reg;
    logic                    ovf_reg;
    logic [MW-1:0]           rd_reg;
    logic                    out_valid_reg;
    logic                    has_item_reg;
    logic [PAYLOAD_BITS-1:0] item_payload_reg;
    logic [STAMP_BITS-1:0]   item_stamp_reg;
    logic                    last_reg;
    logic [OCC_W-1:0]        occupancy_reg;
    logic [OCC_W-1:0]        dropped_reg;
    logic                    overflow_reg;

    cmd_t                  cmd;
    logic                  full;
    logic                  take_all;
    logic [FW-1:0]         n_sel;
    logic [FW-1:0]         start;
    logic [IW-1:0]         oldest_inc;
    logic [IW-1:0]         tail_addr;
    logic [IW-1:0]         walk_first;
    logic [IW-1:0]         walk_inc;
    logic [IW-1:0]         pop_oldest;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [STAMP_BITS-1:0] age;
    logic                  out_free;

    assign cmd        = cmd_t'(command);
    assign full       = (fill_reg == FW'(DEPTH));
    assign take_all   = count[COUNT_W-1] || (count > COUNT_W'(fill_reg));
    assign n_sel      = take_all ? fill_reg : count[FW-1:0];
    assign start      = from_newest ? fill_reg - n_sel : '0;
    assign oldest_inc = wrap(SW'(oldest_reg) + SW'(1));
    assign tail_addr  = wrap(SW'(oldest_reg) + SW'(fill_reg));
    assign walk_first = wrap(SW'(oldest_reg) + SW'(start));
    assign walk_inc   = wrap(SW'(walk_reg) + SW'(1));
    assign pop_oldest = wrap(SW'(oldest_reg) + SW'(n_sel));

    assign wr_en   = ctl.accept && (cmd == CMD_PUSH);
    assign wr_addr = full ? oldest_reg : tail_addr;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = walk_reg;
        if (wr_en)
        begin
            rd_en   = 1'b1;
            rd_addr = full ? oldest_inc : oldest_reg;
        end
        else if (ctl.evict_step)
        begin
            rd_en   = 1'b1;
            rd_addr = oldest_inc;
        end
        else if (ctl.walk_read)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {payload, stamp};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign age      = stamp_reg - rd_reg[STAMP_BITS-1:0];
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        sts.command   = cmd;
        sts.evict_go  = (fill_reg != '0);
        sts.n_zero    = (n_sel == '0);
        sts.too_old   = !age[STAMP_BITS-1] && (CW'(age) > CW'(max_age));
        sts.walk_last = (remain_reg == FW'(1));
        sts.out_free  = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            fill_reg   <= '0;
        end
        else if (ctl.accept)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        oldest_reg <= oldest_inc;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    oldest_reg <= '0;
                    fill_reg   <= '0;
                end
                CMD_POP:
                begin
                    fill_reg <= fill_reg - n_sel;
                    if (!from_newest)
                    begin
                        oldest_reg <= pop_oldest;
                    end
                end
                default:
                begin
                    fill_reg <= fill_reg;
                end
            endcase
        end
        else if (ctl.evict_step)
        begin
            oldest_reg <= oldest_inc;
            fill_reg   <= fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            stamp_reg  <= stamp;
            drp_reg    <= FW'(wr_en && full);
            ovf_reg    <= wr_en && full;
            walk_reg   <= walk_first;
            remain_reg <= n_sel;
        end
        else
        begin
            if (ctl.evict_step)
            begin
                drp_reg <= drp_reg + FW'(1);
            end
            if (ctl.walk_advance)
            begin
                walk_reg   <= walk_inc;
                remain_reg <= remain_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_item || ctl.load_note)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            has_item_reg     <= 1'b1;
            item_payload_reg <= rd_reg[MW-1:STAMP_BITS];
            item_stamp_reg   <= rd_reg[STAMP_BITS-1:0];
            last_reg         <= sts.walk_last;
            occupancy_reg    <= OCC_W'(fill_reg);
            dropped_reg      <= '0;
            overflow_reg     <= 1'b0;
        end
        else if (ctl.load_note)
        begin
            has_item_reg     <= 1'b0;
            item_payload_reg <= '0;
            item_stamp_reg   <= '0;
            last_reg         <= 1'b1;
            occupancy_reg    <= OCC_W'(fill_reg);
            dropped_reg      <= OCC_W'(drp_reg);
            overflow_reg     <= ovf_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.has_item     = has_item_reg;
    assign rsp.item_payload = item_payload_reg;
    assign rsp.item_stamp   = item_stamp_reg;
    assign rsp.last         = last_reg;
    assign rsp.occupancy    = occupancy_reg;
    assign rsp.dropped      = dropped_reg;
    assign rsp.overflow     = overflow_reg;

endmodule

### hdl/time_window_deque_buffer_top.sv
// Sliding time-window FIFO of timestamped words held in a single-port-write,
// registered-read RAM of DEPTH entries. One command word is taken at a time;
// req.ready drops until the last result word of that command is loaded into the
// output register, which then waits for rsp.ready while the next command is taken.
// Clear, empty peek/pop and push into an empty buffer load one final word with no
// entry. Push into a non-empty one first evicts entries by age, reading one stored
// stamp per cycle through the RAM read port (the overflow drop needs no extra
// step), then loads that word. Peek and pop read each entry returned from RAM,
// then load it into the output register, waiting while the output stalls. Results
// are always oldest first; every result reports the occupancy after the command.
// The RAM is not cleared after reset; an entry not yet written is never used.
module time_window_deque_buffer_top
    import twdb_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 64,
    parameter int STAMP_BITS   = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    twdb_in_if.sink           req,
    twdb_out_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    logic [CFG_W-1:0] max_age;
    logic             in_ready;
    dp_ctl_t          ctl;
    dp_sts_t          sts;

    assign pready    = 1'b1;
    assign req.ready = in_ready;

    twdb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .max_age (max_age)
    );

    twdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    twdb_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .STAMP_BITS   (STAMP_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (req.command),
        .payload     (req.payload),
        .stamp       (req.stamp),
        .from_newest (req.from_newest),
        .count       (req.count),
        .max_age     (max_age),
        .ctl         (ctl),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule

### hdl/twdb_checker.sv
module twdb_checker #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 64,
    parameter int STAMP_BITS   = 48
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    has_item,
    input logic [PAYLOAD_BITS-1:0] item_payload,
    input logic [STAMP_BITS-1:0]   item_stamp,
    input logic                    last,
    input logic [6:0]              occupancy,
    input logic [6:0]              dropped,
    input logic                    overflow
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_payload) && $stable(last))
        else $error("result word changed while stalled");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !has_item |-> last && item_payload == '0 && item_stamp == '0)
        else $error("result without entry is not a final, zeroed word");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occupancy <= 7'(DEPTH))
        else $error("occupancy above depth");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && overflow |-> !has_item && dropped != '0 && occupancy == 7'(DEPTH)
            || rsp_valid && overflow && !has_item && dropped > 7'd1)
        else $error("overflow word inconsistent");

endmodule

bind time_window_deque_buffer_top twdb_checker #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .STAMP_BITS   (STAMP_BITS)
) u_twdb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .has_item     (rsp.has_item),
    .item_payload (rsp.item_payload),
    .item_stamp   (rsp.item_stamp),
    .last         (rsp.last),
    .occupancy    (rsp.occupancy),
    .dropped      (rsp.dropped),
    .overflow     (rsp.overflow)
);
